// ===== rtl/core/tcfp_pkg.sv =====
// Shared types and constants for the text code frame parser.
// No dependencies; every module of the parser imports this package.
`default_nettype none

package tcfp_pkg;

    localparam int unsigned NAME_MAX_LEN = 8;
    localparam int unsigned NAME_BYTES   = 8;
    localparam int unsigned DEC_MAX_DIGITS = 15;
    localparam int unsigned HEX_MAX_DIGITS = 16;
    localparam int unsigned BITS_MAX     = 255;

    localparam logic [7:0] CHR_NUL   = 8'h00;
    localparam logic [7:0] CHR_COLON = 8'h3A;
    localparam logic [7:0] CHR_SEMI  = 8'h3B;

    // Byte classification handed from the decoder to the parser.
    typedef struct packed {
        logic       is_nul;
        logic       is_colon;
        logic       is_semi;
        logic       is_dec;
        logic       is_hex;
        logic [3:0] nibble;
    } char_class_t;

    // One parse result.
    typedef struct packed {
        logic        frame_ok;
        logic [63:0] name_text;
        logic [3:0]  name_length;
        logic [7:0]  bit_count;
        logic [63:0] code_value;
    } frame_result_t;

endpackage

`default_nettype wire

// ===== rtl/core/tcfp_char_class.sv =====
// Byte decoder: flags delimiters and decimal/hex digits, gives the nibble value.
// Depends on tcfp_pkg.
`default_nettype none

module tcfp_char_class (
    input  wire logic [7:0]           text_byte,
    output tcfp_pkg::char_class_t     cls
);
    import tcfp_pkg::*;

    logic is_num;
    logic is_lower;
    logic is_upper;

    always_comb
    begin
        is_num   = (text_byte >= 8'h30) && (text_byte <= 8'h39);
        is_lower = (text_byte >= 8'h61) && (text_byte <= 8'h66);
        is_upper = (text_byte >= 8'h41) && (text_byte <= 8'h46);

        cls.is_nul   = (text_byte == CHR_NUL);
        cls.is_colon = (text_byte == CHR_COLON);
        cls.is_semi  = (text_byte == CHR_SEMI);
        cls.is_dec   = is_num;
        cls.is_hex   = is_num || is_lower || is_upper;

        // Letters a-f and A-F share the low nibble pattern 1..6.
        if (is_num)
        begin
            cls.nibble = text_byte[3:0];
        end
        else if (is_lower || is_upper)
        begin
            cls.nibble = text_byte[3:0] + 4'd9;
        end
        else
        begin
            cls.nibble = 4'd0;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/tcfp_parse_fsm.sv =====
// Frame parser state machine: phase, name capture, decimal and hex accumulators.
// Depends on tcfp_pkg; classification comes from tcfp_char_class.
`default_nettype none

module tcfp_parse_fsm (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    step,
    input  wire logic [7:0]              text_byte,
    input  wire tcfp_pkg::char_class_t   cls,
    output logic                         emit,
    output tcfp_pkg::frame_result_t      result
);
    import tcfp_pkg::*;

    typedef enum logic [1:0] {
        PH_NAME,
        PH_BITS,
        PH_HEX,
        PH_SKIP
    } phase_t;

    phase_t      phase_reg,   phase_next;
    logic [63:0] name_reg,    name_next;
    logic [3:0]  name_cnt_reg, name_cnt_next;
    logic [7:0]  dec_acc_reg, dec_acc_next;
    logic        dec_ovf_reg, dec_ovf_next;
    logic [3:0]  dec_cnt_reg, dec_cnt_next;
    logic [63:0] hex_acc_reg, hex_acc_next;
    logic [4:0]  hex_cnt_reg, hex_cnt_next;

    logic        fail;
    logic        clear;
    logic [11:0] dec_sum;

    always_comb
    begin
        phase_next    = phase_reg;
        name_next     = name_reg;
        name_cnt_next = name_cnt_reg;
        dec_acc_next  = dec_acc_reg;
        dec_ovf_next  = dec_ovf_reg;
        dec_cnt_next  = dec_cnt_reg;
        hex_acc_next  = hex_acc_reg;
        hex_cnt_next  = hex_cnt_reg;
        fail          = 1'b0;
        clear         = 1'b0;
        emit          = 1'b0;
        result        = '0;

        dec_sum = {1'b0, dec_acc_reg, 3'b000} + {3'b000, dec_acc_reg, 1'b0}
                + {8'd0, text_byte[3:0]};

        if (cls.is_nul)
        begin
            // End of string: report failure unless already decided.
            emit       = (phase_reg != PH_SKIP);
            phase_next = PH_NAME;
            clear      = 1'b1;
        end
        else
        begin
            unique case (phase_reg)
                PH_NAME:
                begin
                    if (cls.is_colon)
                    begin
                        if (name_cnt_reg == 4'd0)
                            fail = 1'b1;
                        else
                            phase_next = PH_BITS;
                    end
                    else if (name_cnt_reg >= 4'(NAME_MAX_LEN))
                    begin
                        fail = 1'b1;
                    end
                    else
                    begin
                        for (int i = 0; i < NAME_BYTES; i++)
                        begin
                            if (name_cnt_reg[2:0] == 3'(i))
                                name_next[8*i +: 8] = text_byte;
                        end
                        name_cnt_next = name_cnt_reg + 4'd1;
                    end
                end
                PH_BITS:
                begin
                    if (cls.is_colon)
                    begin
                        if ((dec_cnt_reg == 4'd0) || dec_ovf_reg || (dec_acc_reg == 8'd0))
                            fail = 1'b1;
                        else
                            phase_next = PH_HEX;
                    end
                    else if (!cls.is_dec || (dec_cnt_reg >= 4'(DEC_MAX_DIGITS)))
                    begin
                        fail = 1'b1;
                    end
                    else
                    begin
                        dec_cnt_next = dec_cnt_reg + 4'd1;
                        dec_acc_next = dec_sum[7:0];
                        if (dec_sum > 12'(BITS_MAX))
                            dec_ovf_next = 1'b1;
                    end
                end
                PH_HEX:
                begin
                    if (cls.is_semi)
                    begin
                        if (hex_cnt_reg == 5'd0)
                        begin
                            fail = 1'b1;
                        end
                        else
                        begin
                            emit               = 1'b1;
                            result.frame_ok    = 1'b1;
                            result.name_text   = name_reg;
                            result.name_length = name_cnt_reg;
                            result.bit_count   = dec_acc_reg;
                            result.code_value  = hex_acc_reg;
                            phase_next         = PH_SKIP;
                            clear              = 1'b1;
                        end
                    end
                    else if (!cls.is_hex || (hex_cnt_reg >= 5'(HEX_MAX_DIGITS)))
                    begin
                        fail = 1'b1;
                    end
                    else
                    begin
                        hex_cnt_next = hex_cnt_reg + 5'd1;
                        hex_acc_next = {hex_acc_reg[59:0], cls.nibble};
                    end
                end
                PH_SKIP:
                begin
                    // Drop bytes until the terminating NUL.
                end
                default:
                begin
                    phase_next = PH_SKIP;
                end
            endcase

            if (fail)
            begin
                emit       = 1'b1;
                phase_next = PH_SKIP;
                clear      = 1'b1;
            end
        end

        if (clear)
        begin
            name_next     = '0;
            name_cnt_next = '0;
            dec_acc_next  = '0;
            dec_ovf_next  = 1'b0;
            dec_cnt_next  = '0;
            hex_acc_next  = '0;
            hex_cnt_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_NAME;
            name_reg     <= '0;
            name_cnt_reg <= '0;
            dec_acc_reg  <= '0;
            dec_ovf_reg  <= 1'b0;
            dec_cnt_reg  <= '0;
            hex_acc_reg  <= '0;
            hex_cnt_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            name_reg     <= name_next;
            name_cnt_reg <= name_cnt_next;
            dec_acc_reg  <= dec_acc_next;
            dec_ovf_reg  <= dec_ovf_next;
            dec_cnt_reg  <= dec_cnt_next;
            hex_acc_reg  <= hex_acc_next;
            hex_cnt_reg  <= hex_cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/text_code_frame_parser_core.sv =====
// Top level of the text code frame parser: input register, parse step, result register.
// Depends on tcfp_pkg, tcfp_char_class and tcfp_parse_fsm.
//
// Usage:
//   Input channel (in_valid/in_ready/text_byte) carries one byte of a frame
//   NAME:BITS:HEX; per request, terminated by a NUL byte. Output channel
//   (out_valid/out_ready) carries at most one result per frame: frame_ok with
//   the packed name, its length, the bit count and the code value, or all
//   fields zero on a failed frame.
//   Timing: a byte is held in the input register and is parsed as it
//   leaves; a result it decides is loaded into the output register when
//   that byte moves on, and out_valid rises with it.
//   Throughput: one byte per cycle unless stalled as below, set by the
//   combinational parse step between the input and output registers.
//   Stall: when the output register holds an untaken result and the next byte
//   would decide another, that byte waits in the input register and in_ready
//   drops. Bytes that decide nothing keep flowing.
//   Reset: both registers empty, parser back in the name phase with all
//   fields cleared.
`default_nettype none

module text_code_frame_parser_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  text_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             frame_ok,
    output logic [63:0]      name_text,
    output logic [3:0]       name_length,
    output logic [7:0]       bit_count,
    output logic [63:0]      code_value
);
    import tcfp_pkg::*;

    logic          in_valid_reg;
    logic [7:0]    in_byte_reg;
    logic          out_valid_reg;
    frame_result_t out_data_reg;

    char_class_t   cls;
    frame_result_t result;
    logic          emit;
    logic          out_free;
    logic          advance;

    tcfp_char_class u_class (
        .text_byte (in_byte_reg),
        .cls       (cls)
    );

    tcfp_parse_fsm u_fsm (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .text_byte (in_byte_reg),
        .cls       (cls),
        .emit      (emit),
        .result    (result)
    );

    assign out_free = !out_valid_reg || out_ready;
    // Hold the byte only when it decides a result that has nowhere to go.
    assign advance  = in_valid_reg && (!emit || out_free);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance && emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            in_byte_reg <= text_byte;
        if (advance && emit)
            out_data_reg <= result;
    end

    assign out_valid   = out_valid_reg;
    assign frame_ok    = out_data_reg.frame_ok;
    assign name_text   = out_data_reg.name_text;
    assign name_length = out_data_reg.name_length;
    assign bit_count   = out_data_reg.bit_count;
    assign code_value  = out_data_reg.code_value;

endmodule

`default_nettype wire

// ===== test/text_code_frame_parser_core_tb.sv =====
// Self-checking testbench for text_code_frame_parser_core: directed and random NAME:BITS:HEX;
// frames, with a built-in parse predictor and random idling on both channels.
// Depends on tcfp_pkg and the parser RTL only.
module text_code_frame_parser_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tcfp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 10;

    typedef enum logic [1:0] {PH_NAME, PH_BITS, PH_HEX, PH_SKIP} parse_phase_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  text_byte = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        frame_ok;
    logic [63:0] name_text;
    logic [3:0]  name_length;
    logic [7:0]  bit_count;
    logic [63:0] code_value;

    // Parser state mirrored by the predictor
    parse_phase_t ph = PH_NAME;
    logic [63:0]  nm_store = '0;
    logic [3:0]   nm_cnt = '0;
    logic [7:0]   dec_acc = '0;
    logic         dec_ovf = 1'b0;
    logic [3:0]   dec_cnt = '0;
    logic [63:0]  hex_acc = '0;
    logic [4:0]   hex_cnt = '0;

    frame_result_t expected_frames[$];

    int cycles = 0;
    int mismatch_count = 0;
    int parsed_bytes = 0;
    int frames_predicted = 0;
    int frames_good = 0;
    int frames_bad = 0;
    int burst_left = 0;
    int ready_mode = 0;
    int ready_mode_left = 0;
    int ready_hold = 0;
    logic ready_level = 1'b0;

    text_code_frame_parser_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .text_byte   (text_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .frame_ok    (frame_ok),
        .name_text   (name_text),
        .name_length (name_length),
        .bit_count   (bit_count),
        .code_value  (code_value)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     expected_frames.size());
            $display("FAIL");
            $finish;
        end
    end

    task automatic clear_fields();
        nm_store = '0;
        nm_cnt   = '0;
        dec_acc  = '0;
        dec_ovf  = 1'b0;
        dec_cnt  = '0;
        hex_acc  = '0;
        hex_cnt  = '0;
    endtask

    // Advance the parse state by one byte and queue the frame result it decides.
    task automatic parse_char(input logic [7:0] c);
        logic          reject;
        int            dig;
        int            acc;
        frame_result_t res;
        reject = 1'b0;
        dig    = -1;
        res    = '0;
        if (c == CHR_NUL)
        begin
            if (ph != PH_SKIP)
            begin
                expected_frames.push_back('0);
                frames_predicted++;
            end
            ph = PH_NAME;
            clear_fields();
            return;
        end
        case (ph)
            PH_NAME:
                if (c == CHR_COLON)
                begin
                    if (nm_cnt == 0)
                        reject = 1'b1;
                    else
                        ph = PH_BITS;
                end
                else if (nm_cnt >= NAME_MAX_LEN)
                    reject = 1'b1;
                else
                begin
                    nm_store[8*nm_cnt +: 8] = c;
                    nm_cnt++;
                end
            PH_BITS:
                if (c == CHR_COLON)
                begin
                    if (dec_cnt == 0 || dec_ovf || dec_acc == 0)
                        reject = 1'b1;
                    else
                        ph = PH_HEX;
                end
                else if (c < "0" || c > "9" || dec_cnt >= DEC_MAX_DIGITS)
                    reject = 1'b1;
                else
                begin
                    dec_cnt++;
                    acc = int'(dec_acc) * 10 + int'(c - "0");
                    if (acc > BITS_MAX)
                        dec_ovf = 1'b1;
                    dec_acc = acc[7:0];
                end
            PH_HEX:
                if (c == CHR_SEMI)
                begin
                    if (hex_cnt == 0)
                        reject = 1'b1;
                    else
                    begin
                        res.frame_ok    = 1'b1;
                        res.name_text   = nm_store;
                        res.name_length = nm_cnt;
                        res.bit_count   = dec_acc;
                        res.code_value  = hex_acc;
                        expected_frames.push_back(res);
                        frames_predicted++;
                        ph = PH_SKIP;
                        clear_fields();
                    end
                end
                else
                begin
                    if (c >= "0" && c <= "9")
                        dig = int'(c - "0");
                    else if (c >= "a" && c <= "f")
                        dig = int'(c - "a") + 10;
                    else if (c >= "A" && c <= "F")
                        dig = int'(c - "A") + 10;
                    if (dig < 0 || hex_cnt >= HEX_MAX_DIGITS)
                        reject = 1'b1;
                    else
                    begin
                        hex_cnt++;
                        hex_acc = {hex_acc[59:0], 4'(dig)};
                    end
                end
            default:
                ;
        endcase
        if (reject)
        begin
            ph = PH_SKIP;
            clear_fields();
            expected_frames.push_back('0);
            frames_predicted++;
        end
    endtask

    // Send one byte request; idle between random bursts.
    task automatic send_char(input logic [7:0] c);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid  <= 1'b1;
        text_byte <= c;
        do @(posedge clk); while (!in_ready);
        if (ph != PH_SKIP)
            parsed_bytes++;
        parse_char(c);
        burst_left--;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    task automatic send_frame(input string s);
        send_text(s);
        send_char(CHR_NUL);
    endtask

    // Hold the input channel until every queued result has been taken.
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_frames.size() != 0);
    endtask

    // Receiver: switch between always-ready, per-cycle random and alternating held ready and stall stretches.
    always @(posedge clk)
    begin
        if (ready_mode_left == 0)
        begin
            ready_mode      = $urandom_range(0, 2);
            ready_mode_left = $urandom_range(20, 200);
        end
        ready_mode_left--;
        case (ready_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 1) == 1);
            default:
            begin
                if (ready_hold == 0)
                begin
                    ready_level = ~ready_level;
                    ready_hold  = $urandom_range(1, 12);
                end
                ready_hold--;
                out_ready <= ready_level;
            end
        endcase
    end

    always @(posedge clk)
    begin
        frame_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (frame_ok)
                frames_good++;
            else
                frames_bad++;
            if (expected_frames.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display({"unexpected result at cycle %0d: ok %0b name %h len %0d",
                              " bits %0d code %h"},
                             cycles, frame_ok, name_text, name_length, bit_count, code_value);
            end
            else
            begin
                want = expected_frames.pop_front();
                if (frame_ok !== want.frame_ok || name_text !== want.name_text ||
                    name_length !== want.name_length || bit_count !== want.bit_count ||
                    code_value !== want.code_value)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                    begin
                        $display("mismatch at cycle %0d (expected / actual):", cycles);
                        $display("  ok %0b / %0b  len %0d / %0d  bits %0d / %0d",
                                 want.frame_ok, frame_ok, want.name_length, name_length,
                                 want.bit_count, bit_count);
                        $display("  name %h / %h  code %h / %h",
                                 want.name_text, name_text, want.code_value, code_value);
                    end
                end
            end
        end
    end

    task automatic test_good_frames();
        send_frame("A:1:0;");
        send_frame("ABCDEFGH:255:FFFFFFFFFFFFFFFF;");
        send_frame("n:000000000000255:ffffffffffffffff;");
        send_frame("Pr:32:89abcdefABCDEF01;");
        send_frame("x:9:01234567;");
        send_frame("a;b:7:c;");
        // name bytes with the high bit set and control bytes
        send_char(8'hFF);
        send_char(8'h80);
        send_char(8'h01);
        send_char(8'h7F);
        send_text(":8:5;");
        send_char(CHR_NUL);
        send_frame("T:12:aB;junk;::9");
    endtask

    task automatic test_name_errors();
        send_frame(":8:1;");
        send_frame("ABCDEFGHI:8:1;");
    endtask

    task automatic test_bits_errors();
        send_frame("a::1;");
        send_frame("a:1x:1;");
        send_frame("a:0:1;");
        send_frame("a:00:1;");
        send_frame("a:256:1;");
        send_frame("a:999999:1;");
        send_frame("a:0000000000000001:1;");
    endtask

    task automatic test_hex_errors();
        send_frame("a:8:;");
        send_frame("a:8:12g;");
        send_frame("a:8:12:3;");
        send_frame("a:8:00000000000000001;");
    endtask

    task automatic test_early_end();
        send_char(CHR_NUL);
        send_frame("ab");
        send_frame("ab:");
        send_frame("ab:12");
        send_frame("ab:12:f");
        // the second terminator starts and ends an empty string
        send_frame("a:1:2;");
        send_char(CHR_NUL);
    endtask

    task automatic test_drain_pause();
        send_frame("z:3:7;");
        drain_results();
        send_text("q:44:");
        drain_results();
        send_frame("dE;");
        drain_results();
    endtask

    task automatic test_random_frames();
        logic [7:0] frame_q[$];
        string      digits;
        logic [7:0] ch;
        logic [3:0] nib;
        int         name_len;
        int         dec_val;
        int         pad;
        int         hex_len;
        int         pick;
        int         pos;
        int         start_bytes;
        int         start_frames;
        start_bytes  = parsed_bytes;
        start_frames = frames_predicted;
        while (parsed_bytes - start_bytes < 400 || frames_predicted - start_frames < 20)
        begin
            frame_q.delete();
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                repeat ($urandom_range(1, 20))
                begin
                    ch = 8'($urandom_range(0, 255));
                    frame_q.push_back(ch);
                end
            end
            else
            begin
                name_len = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 10)
                                                        : $urandom_range(1, NAME_MAX_LEN);
                repeat (name_len)
                begin
                    do ch = 8'($urandom_range(1, 255)); while (ch == CHR_COLON);
                    frame_q.push_back(ch);
                end
                frame_q.push_back(CHR_COLON);
                dec_val = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 999)
                                                      : $urandom_range(1, BITS_MAX);
                digits = $sformatf("%0d", dec_val);
                pad = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16 - digits.len()) : 0;
                repeat (pad)
                    frame_q.push_back("0");
                for (int i = 0; i < digits.len(); i++)
                    frame_q.push_back(digits[i]);
                frame_q.push_back(CHR_COLON);
                hex_len = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 17)
                                                       : $urandom_range(1, HEX_MAX_DIGITS);
                repeat (hex_len)
                begin
                    nib = 4'($urandom_range(0, 15));
                    if (nib < 10)
                        ch = 8'("0" + nib);
                    else if ($urandom_range(0, 1) == 1)
                        ch = 8'("a" + nib - 10);
                    else
                        ch = 8'("A" + nib - 10);
                    frame_q.push_back(ch);
                end
                frame_q.push_back(CHR_SEMI);
                repeat ($urandom_range(0, 3))
                begin
                    ch = 8'($urandom_range(1, 255));
                    frame_q.push_back(ch);
                end
                // corrupt one byte, or cut the frame short
                if (pick < 20)
                begin
                    pos = $urandom_range(0, frame_q.size() - 1);
                    if (pick < 14)
                        frame_q[pos] = 8'($urandom_range(0, 255));
                    else
                        while (frame_q.size() > pos)
                            void'(frame_q.pop_back());
                end
            end
            frame_q.push_back(CHR_NUL);
            foreach (frame_q[i])
                send_char(frame_q[i]);
            if ($urandom_range(0, 49) == 0)
                drain_results();
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_good_frames();
        test_name_errors();
        test_bits_errors();
        test_hex_errors();
        test_early_end();
        test_drain_pause();
        test_random_frames();
        in_valid <= 1'b0;
        while (expected_frames.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        $display("Parsed %0d bytes in %0d cycles; checked %0d accepted and %0d rejected frames.",
                 parsed_bytes, cycles, frames_good, frames_bad);
        $display("Result mismatches or unexpected results: %0d", mismatch_count);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== text_code_frame_parser_core.f =====
rtl/core/tcfp_pkg.sv
rtl/core/tcfp_char_class.sv
rtl/core/tcfp_parse_fsm.sv
rtl/core/text_code_frame_parser_core.sv
test/text_code_frame_parser_core_tb.sv
